// ===== hdl/encoder_speed_position_estimator_assert.svh =====
// Assertion macros used by the checker file of the encoder speed and position estimator
`ifndef ENCODER_SPEED_POSITION_ESTIMATOR_ASSERT_SVH
`define ENCODER_SPEED_POSITION_ESTIMATOR_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define ESP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ESP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/esp_pkg.sv =====
// Shared constants, types and helper functions of the encoder speed and position estimator
package esp_pkg;

	localparam int PERIOD_BITS   = 24;
	localparam int POSITION_BITS = 32;

	localparam int CPR_BITS      = 16;
	localparam int TMO_BITS      = 24;
	localparam int RATE_BITS     = 28;
	localparam int DATA_BITS     = 32;
	localparam int OUT_BITS      = 32;
	localparam int REG_IDX_BITS  = 2;
	localparam int ADDR_BITS     = REG_IDX_BITS + 2;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_EDGE   = 2'd1;
	localparam logic [1:0] OP_SAMPLE = 2'd2;

	localparam logic [REG_IDX_BITS-1:0] REG_CPR  = REG_IDX_BITS'(0);
	localparam logic [REG_IDX_BITS-1:0] REG_TMO  = REG_IDX_BITS'(1);
	localparam logic [REG_IDX_BITS-1:0] REG_SIDE = REG_IDX_BITS'(2);

	localparam logic [CPR_BITS-1:0] CPR_RESET  = CPR_BITS'(360);
	localparam logic [TMO_BITS-1:0] TMO_RESET  = TMO_BITS'(100000);
	localparam logic                SIDE_RESET = 1'b1;

	localparam logic [RATE_BITS-1:0]   RATE_MAX   = '1;
	localparam logic [RATE_BITS-1:0]   RATE_NUM   = RATE_BITS'(256000000);
	localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

	localparam int KEEP_BITS   = 15;
	localparam int NEW_BITS    = 12;
	localparam int TWO_PI_BITS = 27;
	localparam logic [KEEP_BITS-1:0]   COEF_KEEP = KEEP_BITS'(27984);
	localparam logic [NEW_BITS-1:0]    COEF_NEW  = NEW_BITS'(2386);
	localparam logic [TWO_PI_BITS-1:0] TWO_PI    = TWO_PI_BITS'(105414357);

	localparam int FILT_SHIFT    = 15;
	localparam int ACC_BITS      = RATE_BITS + KEEP_BITS + 1;
	localparam int FILT_W_BITS   = ACC_BITS - FILT_SHIFT;
	localparam logic [ACC_BITS-1:0] FILT_HALF = ACC_BITS'(1) << (FILT_SHIFT - 1);

	localparam int ANG_LIM_SHIFT = 13;
	localparam int MLIM_BITS     = CPR_BITS + ANG_LIM_SHIFT;
	localparam int PROD_BITS     = MLIM_BITS + TWO_PI_BITS;
	localparam int AV_SHIFT      = 15;
	localparam int ANG_SHIFT     = 7;

	localparam int EDGE_DVD_BITS = (PERIOD_BITS > RATE_BITS ? PERIOD_BITS : RATE_BITS) + 1;
	localparam int AV_DVD_BITS   = PROD_BITS - AV_SHIFT + 1;
	localparam int ANG_DVD_BITS  = PROD_BITS - ANG_SHIFT;
	localparam int DVD_A_BITS    = EDGE_DVD_BITS > AV_DVD_BITS ? EDGE_DVD_BITS : AV_DVD_BITS;
	localparam int DVD_BITS      = DVD_A_BITS > ANG_DVD_BITS ? DVD_A_BITS : ANG_DVD_BITS;
	localparam int DVR_BITS      = PERIOD_BITS > (CPR_BITS + 1) ? PERIOD_BITS : (CPR_BITS + 1);
	localparam int DCNT_BITS     = $clog2(DVD_BITS);

	localparam int MAG_CMP_BITS  = POSITION_BITS > MLIM_BITS ? POSITION_BITS : MLIM_BITS;
	localparam int TCMP_BITS     = PERIOD_BITS > TMO_BITS ? PERIOD_BITS : TMO_BITS;

	localparam logic [1:0] DSEL_EDGE = 2'd0;
	localparam logic [1:0] DSEL_AV   = 2'd1;
	localparam logic [1:0] DSEL_ANG  = 2'd2;

	typedef struct packed {
		logic       tick;
		logic       edge_go;
		logic       smp_go;
		logic       filt_mix;
		logic       filt_end;
		logic       mul_av;
		logic       mul_ang;
		logic       div_start;
		logic [1:0] div_sel;
		logic       cap_rate;
		logic       cap_av;
		logic       cap_ang;
		logic       out_load;
	} esp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} esp_sts_t;

	typedef struct packed {
		logic [CPR_BITS-1:0] cpr;
		logic [TMO_BITS-1:0] tmo;
		logic                side;
	} esp_cfg_t;

	function automatic logic [OUT_BITS-1:0] sat_u32(input logic [63:0] v);
		logic [OUT_BITS-1:0] r;
		if (v > 64'h0000_0000_FFFF_FFFF) r = '1;
		else r = v[OUT_BITS-1:0];
		return r;
	endfunction

	function automatic logic [OUT_BITS-1:0] sat_s32(input logic neg, input logic [63:0] mag);
		logic [63:0] lim;
		logic [63:0] neg_v;
		if (neg) begin
			lim = (mag > 64'h0000_0000_8000_0000) ? 64'h0000_0000_8000_0000 : mag;
			neg_v = ~lim + 64'd1;
			return neg_v[OUT_BITS-1:0];
		end else begin
			lim = (mag > 64'h0000_0000_7FFF_FFFF) ? 64'h0000_0000_7FFF_FFFF : mag;
			return lim[OUT_BITS-1:0];
		end
	endfunction

endpackage

// ===== hdl/esp_regs.sv =====
// APB configuration registers: counts per revolution, timeout and wheel side
module esp_regs import esp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output esp_cfg_t             cfg
);

	logic [CPR_BITS-1:0]     cpr_q;
	logic [TMO_BITS-1:0]     tmo_q;
	logic                    side_q;
	logic [REG_IDX_BITS-1:0] idx;
	logic                    wr;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_BITS-1:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q  <= CPR_RESET;
			tmo_q  <= TMO_RESET;
			side_q <= SIDE_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_CPR:  cpr_q  <= pwdata[CPR_BITS-1:0];
				REG_TMO:  tmo_q  <= pwdata[TMO_BITS-1:0];
				REG_SIDE: side_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CPR:  prdata = DATA_BITS'(cpr_q);
			REG_TMO:  prdata = DATA_BITS'(tmo_q);
			REG_SIDE: prdata = DATA_BITS'(side_q);
			default:  prdata = '0;
		endcase
	end

	// zero counts per revolution acts as one
	assign cfg.cpr  = (cpr_q == '0) ? CPR_BITS'(1) : cpr_q;
	assign cfg.tmo  = tmo_q;
	assign cfg.side = side_q;

endmodule

// ===== hdl/esp_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the rate and angle computations
module esp_div import esp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DVD_BITS-1:0] dividend,
	input  logic [DVR_BITS-1:0] divisor,
	output logic [DVD_BITS-1:0] quotient,
	output logic                done
);

	localparam logic [DCNT_BITS-1:0] LAST = DCNT_BITS'(DVD_BITS - 1);

	logic [DVR_BITS-1:0]  rem_q;
	logic [DVD_BITS-1:0]  quo_q;
	logic [DVR_BITS-1:0]  dvr_q;
	logic [DCNT_BITS-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVR_BITS:0]    trial;
	logic [DVR_BITS:0]    diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DVD_BITS-1]};
	assign diff  = trial - {1'b0, dvr_q};
	assign ge    = trial >= {1'b0, dvr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCNT_BITS'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVR_BITS-1:0] : trial[DVR_BITS-1:0];
			quo_q <= {quo_q[DVD_BITS-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== hdl/esp_ctrl.sv =====
// Controller state machine sequencing ticks, edges and samples through the datapath
module esp_ctrl import esp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] opcode,
	output logic       in_ready,
	input  esp_sts_t   sts,
	output esp_cmd_t   cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EDIV = 4'd1;
	localparam logic [3:0] S_MIX  = 4'd2;
	localparam logic [3:0] S_FEND = 4'd3;
	localparam logic [3:0] S_MAV  = 4'd4;
	localparam logic [3:0] S_DAV  = 4'd5;
	localparam logic [3:0] S_WAV  = 4'd6;
	localparam logic [3:0] S_MANG = 4'd7;
	localparam logic [3:0] S_DANG = 4'd8;
	localparam logic [3:0] S_WANG = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       take;

	assign in_ready = (state_q == S_IDLE);
	assign take     = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (opcode)
						OP_TICK: cmd.tick = 1'b1;
						OP_EDGE: begin
							cmd.edge_go   = 1'b1;
							cmd.div_start = 1'b1;
							cmd.div_sel   = DSEL_EDGE;
							state_d       = S_EDIV;
						end
						OP_SAMPLE: begin
							cmd.smp_go = 1'b1;
							state_d    = S_MIX;
						end
						default: ;
					endcase
				end
			end
			S_EDIV: begin
				if (sts.div_done) begin
					cmd.cap_rate = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_MIX: begin
				cmd.filt_mix = 1'b1;
				state_d      = S_FEND;
			end
			S_FEND: begin
				cmd.filt_end = 1'b1;
				state_d      = S_MAV;
			end
			S_MAV: begin
				cmd.mul_av = 1'b1;
				state_d    = S_DAV;
			end
			S_DAV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_AV;
				state_d       = S_WAV;
			end
			S_WAV: begin
				if (sts.div_done) begin
					cmd.cap_av = 1'b1;
					state_d    = S_MANG;
				end
			end
			S_MANG: begin
				cmd.mul_ang = 1'b1;
				state_d     = S_DANG;
			end
			S_DANG: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_ANG;
				state_d       = S_WANG;
			end
			S_WANG: begin
				if (sts.div_done) begin
					cmd.cap_ang = 1'b1;
					state_d     = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

// ===== hdl/esp_dp.sv =====
// Datapath: period counter, edge rate, low-pass filter, position count, multiplier, divider and output register
module esp_dp import esp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  esp_cmd_t            cmd,
	input  esp_cfg_t            cfg,
	input  logic                direction_level,
	input  logic                out_ready,
	output esp_sts_t            sts,
	output logic                out_valid,
	output logic [OUT_BITS-1:0] angular_velocity,
	output logic [OUT_BITS-1:0] position_angle,
	output logic [OUT_BITS-1:0] position_count
);

	logic [PERIOD_BITS-1:0]   period_q;
	logic [RATE_BITS-1:0]     rate_q;
	logic [RATE_BITS-1:0]     filt_q;
	logic [RATE_BITS-1:0]     prev_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     out_valid_q;

	logic [RATE_BITS-1:0]     rcap_q;
	logic                     zero_q;
	logic [ACC_BITS-1:0]      acc_q;
	logic                     neg_q;
	logic [POSITION_BITS-1:0] mag_q;
	logic [MLIM_BITS-1:0]     m_q;
	logic [PROD_BITS-1:0]     prod_q;
	logic [OUT_BITS-1:0]      av_q;
	logic [OUT_BITS-1:0]      ang_q;
	logic [OUT_BITS-1:0]      av_out_q;
	logic [OUT_BITS-1:0]      ang_out_q;
	logic [OUT_BITS-1:0]      cnt_out_q;

	logic [RATE_BITS+KEEP_BITS-1:0]  keep_mul;
	logic [RATE_BITS:0]              mix_sum;
	logic [RATE_BITS+NEW_BITS:0]     new_mul;
	logic [ACC_BITS-1:0]             rnd;
	logic [FILT_W_BITS-1:0]          filt_w;
	logic [MLIM_BITS-1:0]            mul_a;
	logic [PROD_BITS-1:0]            prod_w;
	logic [MAG_CMP_BITS-1:0]         mag_ext;
	logic [MAG_CMP_BITS-1:0]         lim;
	logic                            timed_out;
	logic                            up;
	logic [DVD_BITS-1:0]             dvd;
	logic [DVR_BITS-1:0]             dvr;
	logic [DVD_BITS-1:0]             quo;
	logic                            div_done;

	assign keep_mul  = filt_q * COEF_KEEP;
	assign mix_sum   = {1'b0, rcap_q} + {1'b0, prev_q};
	assign new_mul   = mix_sum * COEF_NEW;
	assign rnd       = acc_q + FILT_HALF;
	assign filt_w    = rnd[ACC_BITS-1:FILT_SHIFT];
	assign mul_a     = cmd.mul_ang ? m_q : MLIM_BITS'(filt_q);
	assign prod_w    = mul_a * TWO_PI;
	assign mag_ext   = MAG_CMP_BITS'(mag_q);
	assign lim       = MAG_CMP_BITS'(cfg.cpr) << ANG_LIM_SHIFT;
	assign timed_out = TCMP_BITS'(period_q) > TCMP_BITS'(cfg.tmo);
	assign up        = cfg.side ? direction_level : !direction_level;

	always_comb begin
		case (cmd.div_sel)
			DSEL_EDGE: begin
				dvd = DVD_BITS'(RATE_NUM) + DVD_BITS'(period_q >> 1);
				dvr = DVR_BITS'(period_q);
			end
			DSEL_AV: begin
				dvd = DVD_BITS'(prod_q >> AV_SHIFT) + DVD_BITS'(cfg.cpr);
				dvr = DVR_BITS'({cfg.cpr, 1'b0});
			end
			DSEL_ANG: begin
				dvd = DVD_BITS'(prod_q >> ANG_SHIFT) + DVD_BITS'(cfg.cpr);
				dvr = DVR_BITS'({cfg.cpr, 1'b0});
			end
			default: begin
				dvd = '0;
				dvr = '0;
			end
		endcase
	end

	esp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvr),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= '0;
			rate_q      <= '0;
			filt_q      <= '0;
			prev_q      <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.tick && period_q != PERIOD_MAX) period_q <= period_q + PERIOD_BITS'(1);
			else if (cmd.edge_go) period_q <= '0;

			if (cmd.edge_go) pos_q <= up ? pos_q + POSITION_BITS'(1) : pos_q - POSITION_BITS'(1);

			if (cmd.cap_rate) begin
				if (zero_q) rate_q <= RATE_MAX;
				else if (quo > DVD_BITS'(RATE_MAX)) rate_q <= RATE_MAX;
				else rate_q <= quo[RATE_BITS-1:0];
			end else if (cmd.smp_go && timed_out) begin
				rate_q <= '0;
			end

			if (cmd.filt_mix) prev_q <= rcap_q;

			if (cmd.filt_end) begin
				if (filt_w > {1'b0, RATE_MAX}) filt_q <= RATE_MAX;
				else filt_q <= filt_w[RATE_BITS-1:0];
			end

			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.edge_go) zero_q <= (period_q == '0);
		if (cmd.smp_go) begin
			rcap_q <= rate_q;
			acc_q  <= ACC_BITS'(keep_mul);
			neg_q  <= pos_q[POSITION_BITS-1];
			mag_q  <= pos_q[POSITION_BITS-1] ? (~pos_q + POSITION_BITS'(1)) : pos_q;
		end
		if (cmd.filt_mix) acc_q <= acc_q + ACC_BITS'(new_mul);
		if (cmd.filt_end) m_q <= (mag_ext > lim) ? lim[MLIM_BITS-1:0] : mag_ext[MLIM_BITS-1:0];
		if (cmd.mul_av || cmd.mul_ang) prod_q <= prod_w;
		if (cmd.cap_av) av_q <= sat_u32(64'(quo));
		if (cmd.cap_ang) ang_q <= sat_s32(neg_q, 64'(quo));
		if (cmd.out_load) begin
			av_out_q  <= av_q;
			ang_out_q <= ang_q;
			cnt_out_q <= sat_s32(neg_q, 64'(mag_q));
		end
	end

	assign sts.div_done     = div_done;
	assign sts.out_free     = !out_valid_q || out_ready;
	assign out_valid        = out_valid_q;
	assign angular_velocity = av_out_q;
	assign position_angle   = ang_out_q;
	assign position_count   = cnt_out_q;

endmodule

// ===== hdl/encoder_speed_position_estimator.sv =====
// Top level of the encoder speed and position estimator. Each transaction on the input channel
// is a microsecond tick, an encoder edge or a sample request; only a sample yields a result.
// After a tick the next transaction may follow at once. An edge holds the input while the
// edge rate comes from the shared restoring divider, one quotient bit a cycle. A sample holds
// it for two passes through that divider (angular velocity, then shaft angle) plus the filter
// and multiply steps, and longer while an earlier result waits in the output register.
// Configuration is written over APB at byte addresses 0, 4 and 8.
module encoder_speed_position_estimator import esp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic                 direction_level,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_BITS-1:0]  angular_velocity,
	output logic [OUT_BITS-1:0]  position_angle,
	output logic [OUT_BITS-1:0]  position_count
);

	esp_cfg_t cfg;
	esp_cmd_t cmd;
	esp_sts_t sts;

	esp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	esp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	esp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg              (cfg),
		.direction_level  (direction_level),
		.out_ready        (out_ready),
		.sts              (sts),
		.out_valid        (out_valid),
		.angular_velocity (angular_velocity),
		.position_angle   (position_angle),
		.position_count   (position_count)
	);

endmodule

// ===== hdl/esp_checker.sv =====
// Port-level assertion checker for the encoder speed and position estimator, with its bind
`include "encoder_speed_position_estimator_assert.svh"

module esp_checker import esp_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [1:0]          opcode,
	input logic                out_valid,
	input logic                out_ready,
	input logic [OUT_BITS-1:0] angular_velocity,
	input logic [OUT_BITS-1:0] position_angle,
	input logic [OUT_BITS-1:0] position_count
);

	`ESP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(angular_velocity) && $stable(position_angle) && $stable(position_count), "stalled result transaction changed")
	`ESP_ASSERT_NOW(a_sign_match, out_valid, position_count[OUT_BITS-1] == position_angle[OUT_BITS-1], "angle sign differs from count sign")
	`ESP_ASSERT_NEXT(a_edge_busy, in_valid && in_ready && opcode == OP_EDGE, !in_ready, "edge transaction did not start the divider")
	`ESP_ASSERT_NEXT(a_tick_ready, in_valid && in_ready && opcode == OP_TICK, in_ready, "tick transaction stalled the input")

endmodule

bind encoder_speed_position_estimator esp_checker u_esp_checker (.*);

// ===== bench/encoder_speed_position_estimator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the encoder speed and position estimator: directed, sweep and random tests
module encoder_speed_position_estimator_tb;
	import esp_pkg::*;

	localparam logic [1:0]  OP_NONE      = 2'd3;
	localparam logic [23:0] PERIOD_FULL  = 24'hFF_FFFF;
	localparam logic [63:0] RATE_CEIL    = 64'h0FFF_FFFF;
	localparam logic [63:0] EDGE_NUM     = 64'd256000000;
	localparam logic [63:0] FILT_KEEP    = 64'd27984;
	localparam logic [63:0] FILT_NEW     = 64'd2386;
	localparam logic [63:0] FILT_ROUND   = 64'd16384;
	localparam logic [63:0] TWO_PI_Q24   = 64'd105414357;
	localparam int          SWEEP_EDGES  = 20;
	localparam int          SETTLE_CYCLES = 150;

	typedef struct packed {
		logic [31:0] velocity;
		logic [31:0] angle;
		logic [31:0] count;
	} reading_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           opcode;
	logic                 direction_level;
	logic                 out_valid;
	logic                 out_ready;
	logic [OUT_BITS-1:0]  angular_velocity;
	logic [OUT_BITS-1:0]  position_angle;
	logic [OUT_BITS-1:0]  position_count;

	logic [15:0] cfg_cpr;
	logic [23:0] cfg_timeout;
	logic        cfg_left;
	logic [23:0] est_period;
	logic [27:0] est_edge_rate;
	logic [27:0] est_filt_rate;
	logic [27:0] est_prev_rate;
	logic [31:0] est_position;

	reading_t pending_readings[$];
	int       error_cnt;
	int       accepted_cnt;
	int       reading_cnt;
	int       cfg_write_cnt;
	int       stall_left;
	bit       in_idle_en;
	bit       out_idle_en;

	encoder_speed_position_estimator uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.direction_level  (direction_level),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.angular_velocity (angular_velocity),
		.position_angle   (position_angle),
		.position_count   (position_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [31:0] clamp_s32(input logic neg, input logic [63:0] mag);
		logic [63:0] m;
		if (neg) begin
			m = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
			return 32'(64'h1_0000_0000 - m);
		end
		m = (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag;
		return m[31:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %08h, want %08h", $realtime, what, got, want);
		error_cnt++;
	endtask

	task automatic estimate_step(input logic [1:0] op, input logic dir);
		logic [63:0] rate;
		logic [63:0] cpr;
		logic [63:0] acc;
		logic [63:0] vel;
		logic [63:0] mag;
		logic [63:0] lim;
		logic [63:0] ang;
		logic        neg;
		logic        up;
		reading_t    r;
		case (op)
		OP_TICK: begin
			if (est_period != PERIOD_FULL)
				est_period++;
		end
		OP_EDGE: begin
			if (est_period == '0) begin
				est_edge_rate = RATE_CEIL[27:0];
			end else begin
				rate = (EDGE_NUM + 64'(est_period) / 2) / 64'(est_period);
				est_edge_rate = (rate > RATE_CEIL) ? RATE_CEIL[27:0] : rate[27:0];
			end
			est_period = '0;
			up = cfg_left ? dir : !dir;
			est_position = up ? est_position + 32'd1 : est_position - 32'd1;
		end
		OP_SAMPLE: begin
			rate = 64'(est_edge_rate);
			cpr = (cfg_cpr == '0) ? 64'd1 : 64'(cfg_cpr);
			if (est_period > cfg_timeout)
				est_edge_rate = '0;
			acc = (FILT_KEEP * 64'(est_filt_rate) + FILT_NEW * rate
				+ FILT_NEW * 64'(est_prev_rate) + FILT_ROUND) >> 15;
			est_filt_rate = (acc > RATE_CEIL) ? RATE_CEIL[27:0] : acc[27:0];
			est_prev_rate = rate[27:0];
			vel = (64'(est_filt_rate) * TWO_PI_Q24 + (cpr << 15)) / (cpr << 16);
			r.velocity = (vel > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : vel[31:0];
			neg = est_position[31];
			mag = neg ? 64'h1_0000_0000 - 64'(est_position) : 64'(est_position);
			lim = cpr << 13;
			ang = ((mag > lim ? lim : mag) * TWO_PI_Q24 + (cpr << 7)) / (cpr << 8);
			r.angle = clamp_s32(neg, ang);
			r.count = clamp_s32(neg, mag);
			pending_readings.push_back(r);
		end
		default: ;
		endcase
	endtask

	task automatic send_item(input logic [1:0] op, input logic dir);
		@(negedge clk);
		while (in_idle_en && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		direction_level <= dir;
		do @(posedge clk); while (!in_ready);
		estimate_step(op, dir);
		accepted_cnt++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
		REG_CPR:  cfg_cpr = value[15:0];
		REG_TMO:  cfg_timeout = value[23:0];
		REG_SIDE: cfg_left = value[0];
		default: ;
		endcase
		cfg_write_cnt++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (out_idle_en && $urandom_range(99) < 24) begin
			out_ready <= 1'b0;
			if ($urandom_range(99) < 1)
				stall_left = $urandom_range(30, 10);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("unexpected result", angular_velocity, '0);
			end else begin
				want = pending_readings.pop_front();
				reading_cnt++;
				if (angular_velocity !== want.velocity)
					report_mismatch("angular_velocity", angular_velocity, want.velocity);
				if (position_angle !== want.angle)
					report_mismatch("position_angle", position_angle, want.angle);
				if (position_count !== want.count)
					report_mismatch("position_count", position_count, want.count);
			end
		end
	end

	task automatic test_basic_ops();
		send_item(OP_SAMPLE, 1'b0);
		send_item(OP_EDGE, 1'b1);
		send_item(OP_NONE, 1'b1);
		repeat (3) send_item(OP_TICK, 1'b1);
		send_item(OP_EDGE, 1'b0);
		send_item(OP_SAMPLE, 1'b1);
		send_item(OP_NONE, 1'b0);
		send_item(OP_SAMPLE, 1'b0);
	endtask

	task automatic test_timeout();
		settle();
		write_reg(REG_TMO, 32'd2);
		repeat (2) send_item(OP_TICK, 1'b0);
		send_item(OP_SAMPLE, 1'b0);
		send_item(OP_TICK, 1'b1);
		send_item(OP_SAMPLE, 1'b0);
		send_item(OP_SAMPLE, 1'b1);
	endtask

	task automatic test_right_side();
		settle();
		write_reg(REG_SIDE, 32'd0);
		write_reg(REG_TMO, 32'hFF_FFFF);
		send_item(OP_EDGE, 1'b0);
		send_item(OP_EDGE, 1'b1);
		send_item(OP_EDGE, 1'b0);
		send_item(OP_SAMPLE, 1'b0);
	endtask

	task automatic test_zero_cpr_sweep();
		settle();
		write_reg(REG_CPR, 32'd0);
		write_reg(REG_SIDE, 32'd1);
		in_idle_en = 1'b0;
		repeat (SWEEP_EDGES) send_item(OP_EDGE, 1'b0);
		send_item(OP_SAMPLE, 1'b0);
		repeat (2 * SWEEP_EDGES) send_item(OP_EDGE, 1'b1);
		send_item(OP_SAMPLE, 1'b1);
		in_idle_en = 1'b1;
	endtask

	task automatic run_random_phase(input logic [15:0] cpr, input logic [23:0] tmo,
			input logic left, input bit idle, input int n_items);
		int sent;
		int pick;
		int run;
		logic [1:0] op;
		settle();
		write_reg(REG_CPR, 32'(cpr));
		write_reg(REG_TMO, 32'(tmo));
		write_reg(REG_SIDE, 32'(left));
		in_idle_en = idle;
		out_idle_en = idle;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				op = 2'($urandom_range(3));
				send_item(op, 1'($urandom_range(1)));
				if (op != OP_NONE)
					sent++;
			end else if (pick < 28) begin
				send_item(OP_SAMPLE, 1'($urandom_range(1)));
				sent++;
			end else begin
				run = ($urandom_range(99) < 3) ? $urandom_range(250, 50) : $urandom_range(8);
				repeat (run) send_item(OP_TICK, 1'($urandom_range(1)));
				send_item(OP_EDGE, 1'($urandom_range(1)));
				sent += run + 1;
				if ($urandom_range(99) < 40) begin
					send_item(OP_SAMPLE, 1'($urandom_range(1)));
					sent++;
				end
			end
		end
		in_idle_en = 1'b1;
		out_idle_en = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		opcode = OP_TICK;
		direction_level = 1'b0;
		out_ready = 1'b0;
		stall_left = 0;
		in_idle_en = 1'b1;
		out_idle_en = 1'b1;
		error_cnt = 0;
		accepted_cnt = 0;
		reading_cnt = 0;
		cfg_write_cnt = 0;
		cfg_cpr = CPR_RESET;
		cfg_timeout = TMO_RESET;
		cfg_left = SIDE_RESET;
		est_period = '0;
		est_edge_rate = '0;
		est_filt_rate = '0;
		est_prev_rate = '0;
		est_position = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_ops();
		test_timeout();
		test_right_side();
		test_zero_cpr_sweep();
		run_random_phase(16'd360, 24'd50, 1'b1, 1'b1, 150);
		run_random_phase(16'd1, 24'd1, 1'b0, 1'b1, 150);
		run_random_phase(16'd65535, 24'hFF_FFFF, 1'b1, 1'b0, 150);
		run_random_phase(16'($urandom_range(65535, 1)), 24'($urandom_range(40, 1)),
			1'($urandom_range(1)), 1'b1, 150);
		run_random_phase(16'($urandom_range(20, 2)), 24'($urandom_range(300, 1)),
			1'($urandom_range(1)), 1'b1, 150);
		run_random_phase(16'd0, 24'd8, 1'b1, 1'b1, 150);
		settle();

		$display("Ran %0d input transactions over %0d register writes; %0d results compared.",
			accepted_cnt, cfg_write_cnt, reading_cnt);
		$display("Included zero period, timeout clear, both sides and zero counts-per-rev sweeps.");
		if (error_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
